// ===== rtl/jacobi_sweep_with_scaling_factor_unit_defines.svh =====
// Assertion macros shared by the Jacobi sweep unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef JACOBI_SWEEP_WITH_SCALING_FACTOR_UNIT_DEFINES_SVH
`define JACOBI_SWEEP_WITH_SCALING_FACTOR_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define JSF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define JSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jsf_pkg.sv =====
// Shared sizes, controller states and control/status structs of the Jacobi sweep unit.
// No dependencies.
package jsf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int EPS_W      = 32;

    // accumulators are signed 64-bit with 2*FRAC_BITS fraction bits
    localparam int SUM_W  = 64;
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int EXT_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

    // shared divider: dividend is a magnitude shifted up by FRAC_BITS
    localparam int DIVD_W = SUM_W + FRAC_BITS;
    localparam int HIGH_W = DIVD_W - DATA_WIDTH;
    localparam int CMP_W  = ((HIGH_W > SUM_W) ? HIGH_W : SUM_W) + 1;
    localparam int REM_W  = SUM_W + 1;
    localparam int CNT_W  = $clog2(DATA_WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_JDIV,
        ST_JFIN,
        ST_STAB,
        ST_FLOAD,
        ST_FDIV,
        ST_FFIN,
        ST_WRITE
    } jsf_state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic step;
        logic jac_done;
        logic stab;
        logic fac_load;
        logic fac_done;
        logic out_load;
    } jsf_cmd_t;

    typedef struct packed {
        logic zero_diag;
        logic last;
        logic out_free;
    } jsf_status_t;

endpackage

// ===== rtl/jsf_divider.sv =====
// Radix-2 restoring divider for unsigned fixed-point fractions, one quotient bit per step.
// Depends on jsf_pkg for the dividend, divisor and quotient widths.
module jsf_divider
    import jsf_pkg::*;
(
    input  logic                    clk,
    input  logic                    load,
    input  logic                    step,
    input  logic [DIVD_W-1:0]       dividend,
    input  logic [SUM_W-1:0]        divisor,
    output logic [DATA_WIDTH-1:0]   quotient,
    output logic                    over
);

    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [DATA_WIDTH-1:0] low_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [SUM_W-1:0]      dsr_reg;
    logic                  over_reg;

    logic [HIGH_W-1:0]     high;
    logic                  over_next;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      dsr_ext;
    logic                  ge;

    // quotient overflows DATA_WIDTH bits when a nonzero dividend's upper part >= divisor
    assign high      = dividend[DIVD_W-1:DATA_WIDTH];
    assign over_next = (dividend != '0) && (CMP_W'(high) >= CMP_W'(divisor));

    // a zero partial remainder never subtracts, so zero over zero gives a zero quotient
    assign dsr_ext  = REM_W'(dsr_reg);
    assign trial    = {rem_reg[REM_W-2:0], low_reg[DATA_WIDTH-1]};
    assign ge       = (trial != '0) && (trial >= dsr_ext);
    assign rem_next = ge ? (trial - dsr_ext) : trial;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= REM_W'(high);
            low_reg  <= dividend[DATA_WIDTH-1:0];
            quo_reg  <= '0;
            dsr_reg  <= divisor;
            over_reg <= over_next;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[DATA_WIDTH-2:0], 1'b0};
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign over     = over_reg;

endmodule

// ===== rtl/jsf_datapath.sv =====
// Datapath of the Jacobi sweep unit: operand capture, products, saturating sums,
// Jacobi update, stabilised ratio and the output register. Uses jsf_pkg and jsf_divider.
module jsf_datapath
    import jsf_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [DATA_WIDTH-1:0] x_value,
    input  logic signed [DATA_WIDTH-1:0] rhs_value,
    input  logic signed [DATA_WIDTH-1:0] product_value,
    input  logic signed [DATA_WIDTH-1:0] diagonal,
    input  logic                         last_element,
    input  logic                         cfg_wr_en,
    input  logic [EPS_W-1:0]             cfg_wr_data,
    input  jsf_cmd_t                     cmd,
    output jsf_status_t                  status,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] x_updated,
    output logic signed [DATA_WIDTH-1:0] scaling_factor,
    output logic                         factor_valid,
    output logic [1:0]                   status_code
);

    localparam int DIFF_W = DATA_WIDTH + 1;
    localparam int TW     = DATA_WIDTH + 3;

    localparam logic signed [EXT_W-1:0] SUM_MAX_E =
        {{(EXT_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SUM_MIN_E =
        {{(EXT_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [TW-1:0] D_MAX_T =
        {{(TW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [TW-1:0] D_MIN_T =
        {{(TW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // operand and intermediate registers
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic signed [DATA_WIDTH-1:0] b_reg;
    logic signed [DATA_WIDTH-1:0] ax_reg;
    logic signed [DATA_WIDTH-1:0] dg_reg;
    logic                         last_reg;
    logic signed [PROD_W-1:0]     pnum_reg;
    logic signed [PROD_W-1:0]     pden_reg;
    logic signed [DIFF_W-1:0]     diff_reg;
    logic signed [DATA_WIDTH-1:0] xu_reg;
    logic signed [DATA_WIDTH-1:0] fac_reg;
    logic signed [SUM_W-1:0]      den_stab_reg;
    logic                         fac_neg_reg;
    logic                         sat_reg;

    // state
    logic signed [SUM_W-1:0]      num_sum_reg;
    logic signed [SUM_W-1:0]      den_sum_reg;
    logic                         sat_flag_reg;
    logic [EPS_W-1:0]             eps_reg;

    // output register
    logic                         out_valid_reg;
    logic signed [DATA_WIDTH-1:0] out_xu_reg;
    logic signed [DATA_WIDTH-1:0] out_fac_reg;
    logic                         out_fv_reg;
    logic [1:0]                   out_status_reg;

    // combinational
    logic signed [EXT_W-1:0]      pnum_e;
    logic signed [EXT_W-1:0]      pden_e;
    logic signed [SUM_W-1:0]      pnum_s;
    logic signed [SUM_W-1:0]      pden_s;
    logic                         pnum_sat;
    logic                         pden_sat;
    logic signed [SUM_W:0]        num_add;
    logic signed [SUM_W:0]        den_add;
    logic signed [SUM_W-1:0]      num_sum_next;
    logic signed [SUM_W-1:0]      den_sum_next;
    logic                         num_ovf;
    logic                         den_ovf;
    logic                         sum_sat;

    logic [DIFF_W-1:0]            diff_mag;
    logic [DATA_WIDTH-1:0]        dg_mag;
    logic [SUM_W-1:0]             num_mag;
    logic [SUM_W-1:0]             stab_mag;
    logic [DIVD_W-1:0]            div_dividend;
    logic [SUM_W-1:0]             div_divisor;
    logic [DATA_WIDTH-1:0]        quo;
    logic                         quo_over;

    logic [DATA_WIDTH:0]          q_eff;
    logic signed [TW-1:0]         t_x;
    logic signed [TW-1:0]         t_q;
    logic signed [TW-1:0]         t_sum;
    logic signed [DATA_WIDTH-1:0] xu_next;
    logic                         xu_sat;

    logic signed [SUM_W:0]        den_e;
    logic signed [SUM_W:0]        eps_e;
    logic signed [SUM_W:0]        stab_sum;
    logic signed [SUM_W-1:0]      stab_next;
    logic                         stab_sat;

    logic                         q_big;
    logic                         q_top;
    logic signed [DATA_WIDTH-1:0] fac_next;
    logic                         fac_sat;

    // products saturated to the accumulator range
    always_comb
    begin
        pnum_e   = EXT_W'(pnum_reg);
        pden_e   = EXT_W'(pden_reg);
        pnum_sat = (pnum_e > SUM_MAX_E) || (pnum_e < SUM_MIN_E);
        pden_sat = (pden_e > SUM_MAX_E) || (pden_e < SUM_MIN_E);
        pnum_s   = (pnum_e > SUM_MAX_E) ? SUM_MAX :
                   (pnum_e < SUM_MIN_E) ? SUM_MIN : pnum_e[SUM_W-1:0];
        pden_s   = (pden_e > SUM_MAX_E) ? SUM_MAX :
                   (pden_e < SUM_MIN_E) ? SUM_MIN : pden_e[SUM_W-1:0];
    end

    // saturating accumulate: overflow shows as differing top two bits
    always_comb
    begin
        num_add      = (SUM_W+1)'(num_sum_reg) + (SUM_W+1)'(pnum_s);
        den_add      = (SUM_W+1)'(den_sum_reg) + (SUM_W+1)'(pden_s);
        num_ovf      = num_add[SUM_W] != num_add[SUM_W-1];
        den_ovf      = den_add[SUM_W] != den_add[SUM_W-1];
        num_sum_next = num_ovf ? (num_add[SUM_W] ? SUM_MIN : SUM_MAX) : num_add[SUM_W-1:0];
        den_sum_next = den_ovf ? (den_add[SUM_W] ? SUM_MIN : SUM_MAX) : den_add[SUM_W-1:0];
        sum_sat      = pnum_sat || pden_sat || num_ovf || den_ovf;
    end

    // magnitudes for the divider
    assign diff_mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign dg_mag   = dg_reg[DATA_WIDTH-1] ? DATA_WIDTH'(-dg_reg) : DATA_WIDTH'(dg_reg);
    assign num_mag  = num_sum_reg[SUM_W-1] ? SUM_W'(-num_sum_reg) : SUM_W'(num_sum_reg);
    assign stab_mag = den_stab_reg[SUM_W-1] ? SUM_W'(-den_stab_reg) : SUM_W'(den_stab_reg);

    always_comb
    begin
        if (cmd.fac_load)
        begin
            div_dividend = {num_mag, {FRAC_BITS{1'b0}}};
            div_divisor  = stab_mag;
        end
        else
        begin
            div_dividend = DIVD_W'({diff_mag, {FRAC_BITS{1'b0}}});
            div_divisor  = SUM_W'(dg_mag);
        end
    end

    jsf_divider u_divider (
        .clk      (clk),
        .load     (cmd.acc || cmd.fac_load),
        .step     (cmd.step),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quo),
        .over     (quo_over)
    );

    // Jacobi update: any quotient at or above 2^DATA_WIDTH saturates the same way
    always_comb
    begin
        q_eff   = quo_over ? {1'b1, {DATA_WIDTH{1'b0}}} : {1'b0, quo};
        t_x     = TW'(x_reg);
        t_q     = $signed(TW'(q_eff));
        t_sum   = (diff_reg[DIFF_W-1] != dg_reg[DATA_WIDTH-1]) ? (t_x - t_q) : (t_x + t_q);
        xu_sat  = (t_sum > D_MAX_T) || (t_sum < D_MIN_T);
        xu_next = (t_sum > D_MAX_T) ? D_MAX :
                  (t_sum < D_MIN_T) ? D_MIN : t_sum[DATA_WIDTH-1:0];
    end

    // push the denominator away from zero by epsilon
    always_comb
    begin
        den_e     = (SUM_W+1)'(den_sum_reg);
        eps_e     = $signed((SUM_W+1)'(eps_reg));
        stab_sum  = den_sum_reg[SUM_W-1] ? (den_e - eps_e) : (den_e + eps_e);
        stab_sat  = stab_sum[SUM_W] != stab_sum[SUM_W-1];
        stab_next = stab_sat ? (stab_sum[SUM_W] ? SUM_MIN : SUM_MAX) : stab_sum[SUM_W-1:0];
    end

    // scaling factor from the quotient magnitude and sign
    always_comb
    begin
        q_top = quo_over || quo[DATA_WIDTH-1];
        q_big = quo_over || (quo[DATA_WIDTH-1] && (quo[DATA_WIDTH-2:0] != '0));
        if (fac_neg_reg)
        begin
            fac_next = q_big ? D_MIN : $signed(-quo);
            fac_sat  = q_big;
        end
        else
        begin
            fac_next = q_top ? D_MAX : $signed(quo);
            fac_sat  = q_top;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg    <= x_value;
            b_reg    <= rhs_value;
            ax_reg   <= product_value;
            dg_reg   <= diagonal;
            last_reg <= last_element;
            fac_reg  <= '0;
        end
        if (cmd.mul)
        begin
            pnum_reg <= b_reg * x_reg;
            pden_reg <= ax_reg * x_reg;
            diff_reg <= DIFF_W'(b_reg) - DIFF_W'(ax_reg);
        end
        if (cmd.jac_done)
        begin
            xu_reg <= status.zero_diag ? x_reg : xu_next;
        end
        if (cmd.stab)
        begin
            den_stab_reg <= stab_next;
        end
        if (cmd.fac_load)
        begin
            fac_neg_reg <= num_sum_reg[SUM_W-1] != den_stab_reg[SUM_W-1];
        end
        if (cmd.fac_done)
        begin
            fac_reg <= fac_next;
        end
        if (cmd.out_load)
        begin
            out_xu_reg     <= xu_reg;
            out_fac_reg    <= fac_reg;
            out_fv_reg     <= last_reg;
            out_status_reg <= {sat_reg, status.zero_diag};
        end
    end

    // per-item saturation status
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sat_reg <= 1'b0;
        end
        else if (cmd.acc)
        begin
            sat_reg <= sat_reg || sum_sat;
        end
        else if (cmd.jac_done)
        begin
            sat_reg <= sat_reg || (xu_sat && !status.zero_diag);
        end
        else if (cmd.stab)
        begin
            sat_reg <= sat_reg || stab_sat || sat_flag_reg;
        end
        else if (cmd.fac_done)
        begin
            sat_reg <= sat_reg || fac_sat;
        end
    end

    // sweep state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sum_reg  <= '0;
            den_sum_reg  <= '0;
            sat_flag_reg <= 1'b0;
            eps_reg      <= EPS_W'(1);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                eps_reg <= cfg_wr_data;
            end
            if (cmd.acc)
            begin
                num_sum_reg  <= num_sum_next;
                den_sum_reg  <= den_sum_next;
                sat_flag_reg <= sat_flag_reg || sum_sat;
            end
            else if (cmd.fac_done)
            begin
                // end of sweep: drop the sums for the next one
                num_sum_reg  <= '0;
                den_sum_reg  <= '0;
                sat_flag_reg <= 1'b0;
            end
        end
    end

    // output valid: set on load, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.zero_diag = dg_reg == '0;
    assign status.last      = last_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign x_updated      = out_xu_reg;
    assign scaling_factor = out_fac_reg;
    assign factor_valid   = out_fv_reg;
    assign status_code    = out_status_reg;

endmodule

// ===== rtl/jsf_ctrl.sv =====
// Controller of the Jacobi sweep unit: sequences capture, accumulate and divider steps.
// Uses jsf_pkg and the assertion macros header.
`include "jacobi_sweep_with_scaling_factor_unit_defines.svh"

module jsf_ctrl
    import jsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  jsf_status_t status,
    output jsf_cmd_t    cmd
);

    jsf_state_t       state_reg;
    jsf_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             cnt_done;

    assign cnt_done = cnt_reg == CNT_W'(DATA_WIDTH - 1);
    assign in_stall = state_reg != ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cnt_next   = '0;
                state_next = status.zero_diag ? ST_JFIN : ST_JDIV;
            end
            ST_JDIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_done)
                begin
                    state_next = ST_JFIN;
                end
            end
            ST_JFIN:
            begin
                state_next = status.last ? ST_STAB : ST_WRITE;
            end
            ST_STAB:
            begin
                state_next = ST_FLOAD;
            end
            ST_FLOAD:
            begin
                cnt_next   = '0;
                state_next = ST_FDIV;
            end
            ST_FDIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_done)
                begin
                    state_next = ST_FFIN;
                end
            end
            ST_FFIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:  cmd.capture  = in_valid;
            ST_MUL:   cmd.mul      = 1'b1;
            ST_ACC:   cmd.acc      = 1'b1;
            ST_JDIV:  cmd.step     = 1'b1;
            ST_JFIN:  cmd.jac_done = 1'b1;
            ST_STAB:  cmd.stab     = 1'b1;
            ST_FLOAD: cmd.fac_load = 1'b1;
            ST_FDIV:  cmd.step     = 1'b1;
            ST_FFIN:  cmd.fac_done = 1'b1;
            ST_WRITE: cmd.out_load = status.out_free;
            default:  cmd = '0;
        endcase
    end

    `JSF_ASSERT_NEXT(a_accept_starts_item, in_valid && !in_stall, state_reg == ST_MUL, "accepted item did not start")
    `JSF_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command at once")
    `JSF_ASSERT_SAME(a_load_needs_room, cmd.out_load, status.out_free, "result loaded over a waiting result")
    `JSF_ASSERT_SAME(a_ratio_only_on_last, state_reg == ST_STAB, status.last, "ratio computed for an inner element")

endmodule

// ===== rtl/jacobi_sweep_with_scaling_factor_unit.sv =====
// Jacobi sweep unit with correction scaling factor: top level.
// Joins jsf_ctrl and jsf_datapath; uses jsf_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one vector element per transfer:
//   x_value, rhs_value, product_value, diagonal (signed Q16.16) and last_element.
//   Output channel (out_valid/out_stall) gives one result per element:
//   x_updated, scaling_factor, factor_valid and status.
//   cfg_wr_en/cfg_wr_data write the stabilising epsilon (unsigned Q0.32, reset value 2^-32).
// Sequencing:
//   An element holds in_stall high from its transfer until its result is loaded
//   into the output register; the shared radix-2 divider gives one quotient bit
//   a cycle. A zero diagonal skips the divider; the last element of a sweep
//   runs it twice.
// Reset clears the sums, the sticky saturation flag and both channels, and
// loads epsilon with 2^-32. A stalled receiver holds the result in the output
// register; the next element is still taken and worked on, and waits only
// to load its own result until the output register is free.
module jacobi_sweep_with_scaling_factor_unit
    import jsf_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] x_value,
    input  logic signed [DATA_WIDTH-1:0] rhs_value,
    input  logic signed [DATA_WIDTH-1:0] product_value,
    input  logic signed [DATA_WIDTH-1:0] diagonal,
    input  logic                         last_element,
    input  logic                         cfg_wr_en,
    input  logic [EPS_W-1:0]             cfg_wr_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] x_updated,
    output logic signed [DATA_WIDTH-1:0] scaling_factor,
    output logic                         factor_valid,
    output logic [1:0]                   status
);

    jsf_cmd_t    cmd;
    jsf_status_t dp_status;

    jsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (cmd)
    );

    jsf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .x_value        (x_value),
        .rhs_value      (rhs_value),
        .product_value  (product_value),
        .diagonal       (diagonal),
        .last_element   (last_element),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .status         (dp_status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .x_updated      (x_updated),
        .scaling_factor (scaling_factor),
        .factor_valid   (factor_valid),
        .status_code    (status)
    );

endmodule
